>>> hw/rtl/bf2d_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the 2-D box filter.
// No dependencies.
package bf2d_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_WINDOW = 15;
  localparam int HALF_MAX   = (MAX_WINDOW - 1) / 2;
  localparam int RING_ROWS  = 2 * HALF_MAX + 2;
  localparam int RING_BITS  = $clog2(RING_ROWS);
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int ADDR_BITS  = RING_BITS + COL_BITS;
  localparam int RAM_DEPTH  = RING_ROWS * MAX_WIDTH;

  localparam logic [1:0] REG_WINDOW_SIZE  = 2'd0;
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam logic KIND_PIXEL = 1'b0;

  typedef struct packed {
    logic [2:0]  half;
    logic [10:0] w;
    logic [12:0] h;
    logic [7:0]  div;
  } geom_t;

  typedef struct packed {
    logic [11:0] r0;
    logic [11:0] r1;
    logic [9:0]  c0;
    logic [9:0]  c1;
    logic [7:0]  div;
    logic        last;
  } job_t;

  typedef struct packed {
    logic                 en;
    logic [ADDR_BITS-1:0] addr;
    logic [7:0]           data;
  } wr_t;

  typedef enum logic [1:0] {F_TAKE, F_EVAL, F_WAIT} front_st_t;
  typedef enum logic [2:0] {B_IDLE, B_SUM, B_TAIL, B_DIV, B_OUT} back_st_t;

  function automatic geom_t geom_from_cfg(logic [3:0] k, logic [10:0] w, logic [12:0] h);
    geom_t g;
    logic [2:0] hf;
    logic [3:0] side;
    logic [7:0] sq;
    hf = (k[3:1] > 3'(HALF_MAX)) ? 3'(HALF_MAX) : k[3:1];
    side = {hf, 1'b1};
    sq = 8'(side) * 8'(side);
    g.half = hf;
    g.div = sq;
    if (w == 11'd0) g.w = 11'd1;
    else if (w > 11'(MAX_WIDTH)) g.w = 11'(MAX_WIDTH);
    else g.w = w;
    g.h = (h == 13'd0) ? 13'd1 : h;
    return g;
  endfunction

endpackage

>>> hw/rtl/bf2d_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bf2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;
endmodule

>>> hw/rtl/bf2d_queue.sv
`timescale 1ns / 1ps
// Two-entry job queue between front and back.
// Depends on bf2d_pkg.
module bf2d_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bf2d_pkg::job_t push_job,
  input  logic           pop,
  output logic           not_empty,
  output bf2d_pkg::job_t head
);
  import bf2d_pkg::*;

  job_t       slot_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt = push ? ~wp_r : wp_r;
    rp_nxt = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      slot_r[wp_r] <= push_job;
    end
  end

  assign not_empty = (cnt_r != 2'd0);
  assign head = slot_r[rp_r];
endmodule

>>> hw/rtl/bf2d_front.sv
`timescale 1ns / 1ps
// Front end: takes items, stores pixels, tracks frame position, issues window jobs.
// Depends on bf2d_pkg.
module bf2d_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,
  input  logic            in_tuser,
  input  bf2d_pkg::geom_t cfg_geom,
  input  logic            job_done,
  output bf2d_pkg::wr_t   wr,
  output logic            push,
  output bf2d_pkg::job_t  job
);
  import bf2d_pkg::*;

  front_st_t   st_r, st_nxt;
  geom_t       cur_r, cur_nxt, g;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [12:0] in_row_r, in_row_nxt;
  logic [9:0]  in_col_r, in_col_nxt;
  logic [11:0] out_row_r, out_row_nxt;
  logic [9:0]  out_col_r, out_col_nxt;
  logic        take, start, store, busy_eff, ready, last;
  logic [12:0] nr_raw, nr;
  logic [10:0] nc_raw, nc;

  assign take = in_tvalid && in_tready;
  assign start = take && (in_tuser == KIND_PIXEL) && !busy_r;
  assign busy_eff = busy_r || start;
  assign store = take && (in_tuser == KIND_PIXEL) && busy_eff && !done_r;
  assign g = start ? cfg_geom : cur_r;

  always_comb begin
    nr_raw = 13'(out_row_r) + 13'(cur_r.half);
    nr = (nr_raw > cur_r.h - 13'd1) ? cur_r.h - 13'd1 : nr_raw;
    nc_raw = 11'(out_col_r) + 11'(cur_r.half);
    nc = (nc_raw > cur_r.w - 11'd1) ? cur_r.w - 11'd1 : nc_raw;
    ready = done_r || (in_row_r > nr) || (in_row_r == nr && 11'(in_col_r) > nc);
    last = (13'(out_row_r) == cur_r.h - 13'd1) && (11'(out_col_r) == cur_r.w - 11'd1);
    job.r0 = (out_row_r >= 12'(cur_r.half)) ? out_row_r - 12'(cur_r.half) : 12'd0;
    job.r1 = nr[11:0];
    job.c0 = (out_col_r >= 10'(cur_r.half)) ? out_col_r - 10'(cur_r.half) : 10'd0;
    job.c1 = nc[9:0];
    job.div = cur_r.div;
    job.last = last;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      F_TAKE: if (take) st_nxt = F_EVAL;
      F_EVAL: st_nxt = (busy_r && ready) ? F_WAIT : F_TAKE;
      F_WAIT: if (job_done) st_nxt = F_TAKE;
      default: st_nxt = F_TAKE;
    endcase
  end

  always_comb begin
    in_tready = (st_r == F_TAKE);
    push = (st_r == F_EVAL) && busy_r && ready;
    wr.en = store;
    wr.addr = {in_row_r[RING_BITS-1:0], in_col_r};
    wr.data = in_tdata;
  end

  always_comb begin
    cur_nxt = g;
    busy_nxt = busy_eff;
    done_nxt = done_r;
    in_row_nxt = in_row_r;
    in_col_nxt = in_col_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    if (store) begin
      if (11'(in_col_r) + 11'd1 >= g.w) begin
        in_col_nxt = 10'd0;
        in_row_nxt = in_row_r + 13'd1;
        if (in_row_r + 13'd1 >= g.h) done_nxt = 1'b1;
      end else begin
        in_col_nxt = in_col_r + 10'd1;
      end
    end
    if (push) begin
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b0;
        in_row_nxt = 13'd0;
        in_col_nxt = 10'd0;
        out_row_nxt = 12'd0;
        out_col_nxt = 10'd0;
      end else if (11'(out_col_r) + 11'd1 >= cur_r.w) begin
        out_col_nxt = 10'd0;
        out_row_nxt = out_row_r + 12'd1;
      end else begin
        out_col_nxt = out_col_r + 10'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_TAKE;
      cur_r <= geom_from_cfg(4'd3, 11'd640, 13'd480);
      busy_r <= 1'b0;
      done_r <= 1'b0;
      in_row_r <= 13'd0;
      in_col_r <= 10'd0;
      out_row_r <= 12'd0;
      out_col_r <= 10'd0;
    end else begin
      st_r <= st_nxt;
      cur_r <= cur_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      in_row_r <= in_row_nxt;
      in_col_r <= in_col_nxt;
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
    end
  end
endmodule

>>> hw/rtl/bf2d_back.sv
`timescale 1ns / 1ps
// Back end: sums one window from the row store, divides, holds the result item.
// Depends on bf2d_pkg.
module bf2d_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           job_valid,
  input  bf2d_pkg::job_t                 job_in,
  output logic                           pop,
  output logic [bf2d_pkg::ADDR_BITS-1:0] rd_addr,
  input  logic [7:0]                     rd_data,
  output logic                           job_done,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,
  output logic                           out_tlast
);
  import bf2d_pkg::*;

  back_st_t    st_r, st_nxt;
  job_t        job_r;
  logic [11:0] r_r, r_nxt;
  logic [9:0]  c_r, c_nxt;
  logic        acc_r;
  logic [15:0] sum_r, sum_nxt;
  logic [8:0]  rem_r, rem_nxt, trial;
  logic [7:0]  quo_r, quo_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        vld_r, vld_nxt, load;
  logic [7:0]  dat_r;
  logic        lst_r;

  assign trial = {rem_r[7:0], sum_r[4'd15 - cnt_r]};

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      B_IDLE: if (job_valid) st_nxt = B_SUM;
      B_SUM: if (c_r == job_r.c1 && r_r == job_r.r1) st_nxt = B_TAIL;
      B_TAIL: st_nxt = B_DIV;
      B_DIV: if (cnt_r == 4'd15) st_nxt = B_OUT;
      B_OUT: if (!vld_r || out_tready) st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    pop = (st_r == B_IDLE) && job_valid;
    load = (st_r == B_OUT) && (!vld_r || out_tready);
    job_done = load;
    rd_addr = {r_r[RING_BITS-1:0], c_r};
  end

  always_comb begin
    r_nxt = r_r;
    c_nxt = c_r;
    sum_nxt = acc_r ? sum_r + 16'(rd_data) : sum_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    vld_nxt = (vld_r && !out_tready) || load;
    case (st_r)
      B_IDLE: begin
        r_nxt = job_in.r0;
        c_nxt = job_in.c0;
        sum_nxt = 16'd0;
      end
      B_SUM: begin
        if (c_r == job_r.c1) begin
          c_nxt = job_r.c0;
          r_nxt = r_r + 12'd1;
        end else begin
          c_nxt = c_r + 10'd1;
        end
      end
      B_TAIL: begin
        rem_nxt = 9'd0;
        quo_nxt = 8'd0;
        cnt_nxt = 4'd0;
      end
      B_DIV: begin
        if (trial >= 9'(job_r.div)) begin
          rem_nxt = trial - 9'(job_r.div);
          quo_nxt = {quo_r[6:0], 1'b1};
        end else begin
          rem_nxt = trial;
          quo_nxt = {quo_r[6:0], 1'b0};
        end
        cnt_nxt = cnt_r + 4'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      acc_r <= 1'b0;
      vld_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      acc_r <= (st_r == B_SUM);
      vld_r <= vld_nxt;
    end
    if (pop) job_r <= job_in;
    r_r <= r_nxt;
    c_r <= c_nxt;
    sum_r <= sum_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    if (load) begin
      dat_r <= quo_r;
      lst_r <= job_r.last;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata = dat_r;
  assign out_tlast = lst_r;
endmodule

>>> hw/rtl/box_filter_2d_unit.sv
`timescale 1ns / 1ps
// Top level of the streaming 2-D box (mean) filter with zero padding.
// Depends on bf2d_pkg, bf2d_ram, bf2d_queue, bf2d_front, bf2d_back.
//
// Usage:
//   in_*  : items in raster order; tuser 0 = pixel (tdata), 1 = drain tick.
//   out_* : one filtered pixel per frame position, tlast on the last of the frame.
//   cfg_* : register writes (0 window size, 1 frame width, 2 frame height),
//           always ready; values are taken when the first pixel of a frame arrives.
// Throughput: one item at a time. For an item with a result, the back end reads
// the row store once per pixel of the K x K window (clipped at frame edges),
// then runs a 16-step restoring divide.
// Reset clears all control state and restores register defaults (3, 640, 480);
// the row store needs no clearing. A stalled receiver holds the result in the
// output register; the back end waits and no new item is taken until it loads.
module box_filter_2d_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] pixel_in
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] filtered
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import bf2d_pkg::*;

  logic [3:0]  win_r;
  logic [10:0] wid_r;
  logic [12:0] hgt_r;
  geom_t       cfg_geom;
  wr_t         wr;
  logic        push, pop, q_ne, job_done;
  job_t        job_f, job_q;
  logic [ADDR_BITS-1:0] rd_addr;
  logic [7:0]  rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= 4'd3;
      wid_r <= 11'd640;
      hgt_r <= 13'd480;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WINDOW_SIZE:  win_r <= cfg_data[3:0];
        REG_FRAME_WIDTH:  wid_r <= cfg_data[10:0];
        REG_FRAME_HEIGHT: hgt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_geom = geom_from_cfg(win_r, wid_r, hgt_r);

  bf2d_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram (
    .clk(clk), .wr_en(wr.en), .wr_addr(wr.addr), .wr_data(wr.data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  bf2d_front u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .cfg_geom(cfg_geom),
    .job_done(job_done), .wr(wr), .push(push), .job(job_f)
  );

  bf2d_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_job(job_f), .pop(pop),
    .not_empty(q_ne), .head(job_q)
  );

  bf2d_back u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(q_ne), .job_in(job_q), .pop(pop),
    .rd_addr(rd_addr), .rd_data(rd_data), .job_done(job_done),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );
endmodule
